// ===== rtl/front_light_fade_blink_controller_macros.svh =====
// Assertion macros for the front light fade and blink controller.
`ifndef FRONT_LIGHT_FADE_BLINK_CONTROLLER_MACROS_SVH
`define FRONT_LIGHT_FADE_BLINK_CONTROLLER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every edge, held off during reset.
`define FLFB_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define FLFB_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FLFB_ASSERT_RST(lbl, clk, rst, prop, msg)
`define FLFB_ASSERT(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/flfb_pkg.sv =====
// Shared types and constants of the front light fade and blink controller.
package flfb_pkg;

  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_LIGHT_ON    = 3'd1,
    ACT_LIGHT_OFF   = 3'd2,
    ACT_BLINK_START = 3'd3,
    ACT_BLINK_STOP  = 3'd4,
    ACT_SET_BRIGHT  = 3'd5
  } flfb_action_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_IVL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_IVL = 2'd1;

  localparam logic [15:0] FADE_IVL_RESET  = 16'd16;
  localparam logic [15:0] BLINK_IVL_RESET = 16'd250;
  localparam logic [7:0]  LEVEL_FULL      = 8'd255;
  localparam logic [7:0]  BRIGHT_RESET    = 8'd255;
  localparam logic [8:0]  RAMP_KNEE       = 9'd50;

  typedef struct packed {
    logic [7:0] level;
    logic [7:0] scale;
    logic       on;
    logic       blink;
    logic       fade;
  } flfb_result_t;

endpackage

// ===== rtl/flfb_core.sv =====
// Controller state and its single-pass update for one item.
`include "front_light_fade_blink_controller_macros.svh"

module flfb_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [2:0]           action,
  input  logic [7:0]           value,
  input  logic [15:0]          fade_ivl_cfg,
  input  logic [15:0]          blink_ivl_cfg,
  output flfb_pkg::flfb_result_t result
);
  import flfb_pkg::*;

  logic [7:0]        bright_reg, bright_reg_next;
  logic              blink_flag, blink_flag_next;
  logic              on_flag, on_flag_next;
  logic              fade_up_dir, fade_up_dir_next;
  logic [8:0]        ramp_up, ramp_up_next;
  logic signed [9:0] ramp_dn, ramp_dn_next;
  logic              fade_run, fade_run_next;
  logic [15:0]       fade_left, fade_left_next;
  logic              blink_run, blink_run_next;
  logic [15:0]       blink_left, blink_left_next;
  logic [7:0]        level_reg, level_reg_next;

  logic [15:0]       fade_ivl, blink_ivl, fade_dec, blink_dec;
  logic [8:0]        ramp_up_inc;
  logic signed [9:0] ramp_dn_dec;
  flfb_action_t      act;

  assign act         = flfb_action_t'(action);
  assign fade_ivl    = (fade_ivl_cfg == 16'd0) ? 16'd1 : fade_ivl_cfg;
  assign blink_ivl   = (blink_ivl_cfg == 16'd0) ? 16'd1 : blink_ivl_cfg;
  assign fade_dec    = fade_left - 16'd1;
  assign blink_dec   = blink_left - 16'd1;
  assign ramp_up_inc = ramp_up + ((ramp_up < RAMP_KNEE) ? 9'd1 : 9'd2);
  assign ramp_dn_dec = ramp_dn - 10'sd2;

  always_comb begin
    bright_reg_next  = bright_reg;
    blink_flag_next  = blink_flag;
    on_flag_next     = on_flag;
    fade_up_dir_next = fade_up_dir;
    ramp_up_next     = ramp_up;
    ramp_dn_next     = ramp_dn;
    fade_run_next    = fade_run;
    fade_left_next   = fade_left;
    blink_run_next   = blink_run;
    blink_left_next  = blink_left;
    level_reg_next   = level_reg;
    if (step) begin
      unique case (act)
        ACT_TICK: begin
          // fade timer first, then blink timer
          if (fade_run) begin
            fade_left_next = fade_dec;
            if (fade_dec == 16'd0) begin
              fade_run_next = 1'b0;
              if (fade_up_dir) begin
                ramp_dn_next = 10'sd255;
                if (ramp_up_inc < {1'b0, bright_reg}) begin
                  ramp_up_next   = ramp_up_inc;
                  level_reg_next = ramp_up_inc[7:0];
                  fade_run_next  = 1'b1;
                  fade_left_next = fade_ivl;
                end else begin
                  ramp_up_next   = 9'd0;
                  ramp_dn_next   = {2'b00, bright_reg};
                  level_reg_next = bright_reg;
                end
              end else begin
                ramp_up_next = 9'd0;
                if (ramp_dn_dec > 10'sd0) begin
                  ramp_dn_next   = ramp_dn_dec;
                  level_reg_next = ramp_dn_dec[7:0];
                  fade_run_next  = 1'b1;
                  fade_left_next = fade_ivl;
                end else begin
                  ramp_dn_next   = {2'b00, bright_reg};
                  level_reg_next = 8'd0;
                end
              end
            end
          end
          if (blink_run) begin
            blink_left_next = blink_dec;
            if (blink_dec == 16'd0) begin
              blink_run_next = 1'b0;
              if (blink_flag) begin
                on_flag_next    = !on_flag;
                level_reg_next  = on_flag ? 8'd0 : LEVEL_FULL;
                blink_run_next  = 1'b1;
                blink_left_next = blink_ivl;
              end
            end
          end
        end
        ACT_LIGHT_ON: begin
          fade_up_dir_next = 1'b1;
          fade_run_next    = 1'b1;
          fade_left_next   = fade_ivl;
          blink_flag_next  = 1'b0;
          on_flag_next     = 1'b1;
        end
        ACT_LIGHT_OFF: begin
          fade_up_dir_next = 1'b0;
          fade_run_next    = 1'b1;
          fade_left_next   = fade_ivl;
          on_flag_next     = 1'b0;
        end
        ACT_BLINK_START: begin
          blink_flag_next = 1'b1;
          on_flag_next    = !on_flag;
          level_reg_next  = on_flag ? 8'd0 : LEVEL_FULL;
          blink_run_next  = 1'b1;
          blink_left_next = blink_ivl;
        end
        ACT_BLINK_STOP: begin
          blink_flag_next = 1'b0;
        end
        ACT_SET_BRIGHT: begin
          bright_reg_next = value;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bright_reg  <= BRIGHT_RESET;
      blink_flag  <= 1'b0;
      on_flag     <= 1'b0;
      fade_up_dir <= 1'b0;
      ramp_up     <= 9'd0;
      ramp_dn     <= 10'sd255;
      fade_run    <= 1'b0;
      fade_left   <= 16'd0;
      blink_run   <= 1'b0;
      blink_left  <= 16'd0;
      level_reg   <= 8'd0;
    end else begin
      bright_reg  <= bright_reg_next;
      blink_flag  <= blink_flag_next;
      on_flag     <= on_flag_next;
      fade_up_dir <= fade_up_dir_next;
      ramp_up     <= ramp_up_next;
      ramp_dn     <= ramp_dn_next;
      fade_run    <= fade_run_next;
      fade_left   <= fade_left_next;
      blink_run   <= blink_run_next;
      blink_left  <= blink_left_next;
      level_reg   <= level_reg_next;
    end
  end

  assign result.level = level_reg_next;
  assign result.scale = bright_reg_next;
  assign result.on    = on_flag_next;
  assign result.blink = blink_flag_next;
  assign result.fade  = fade_run_next;

  `FLFB_ASSERT_RST(a_fade_left_live, clk, rst, fade_run |-> (fade_left != 16'd0),
    "running fade timer has zero count")
  `FLFB_ASSERT_RST(a_blink_left_live, clk, rst, blink_run |-> (blink_left != 16'd0),
    "running blink timer has zero count")
  `FLFB_ASSERT_RST(a_ramp_up_range, clk, rst, !ramp_up[8],
    "ramp-up count left 8-bit range")
  `FLFB_ASSERT_RST(a_ramp_dn_range, clk, rst, ramp_dn >= -10'sd1,
    "ramp-down count below -1")

endmodule

// ===== rtl/front_light_fade_blink_controller.sv =====
// Top level: input register, state update, output register and config port.
// Each command or tick item is taken into an input register, updated against
// the controller state in one pass and held in an output register; one item
// is accepted per cycle while in_stall is low.
// Throughput is set by the single state-update pass, which keeps one item per
// cycle as long as the output side does not stall. Config writes are taken in
// any cycle and must only happen while no item is in flight.
`include "front_light_fade_blink_controller_macros.svh"

module front_light_fade_blink_controller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     action,
  input  logic [7:0]                     value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     led_level,
  output logic [7:0]                     led_scale,
  output logic                           light_on,
  output logic                           blinking,
  output logic                           fade_active,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [flfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import flfb_pkg::*;

  logic         s1_valid;
  logic [2:0]   s1_action;
  logic [7:0]   s1_value;
  logic         adv;
  logic [15:0]  fade_ivl, blink_ivl;
  flfb_result_t result;

  assign adv       = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_ivl  <= FADE_IVL_RESET;
      blink_ivl <= BLINK_IVL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FADE_IVL) begin
        fade_ivl <= cfg_data;
      end else if (cfg_index == CFG_BLINK_IVL) begin
        blink_ivl <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_action <= action;
      s1_value  <= value;
    end
  end

  flfb_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (adv),
    .action        (s1_action),
    .value         (s1_value),
    .fade_ivl_cfg  (fade_ivl),
    .blink_ivl_cfg (blink_ivl),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      led_level   <= result.level;
      led_scale   <= result.scale;
      light_on    <= result.on;
      blinking    <= result.blink;
      fade_active <= result.fade;
    end
  end

  `FLFB_ASSERT_RST(a_adv_fills_out, clk, rst, adv |=> out_valid,
    "advanced item did not reach output register")
  `FLFB_ASSERT_RST(a_stall_needs_item, clk, rst, in_stall |-> (s1_valid && out_valid),
    "input stalled without a blocked item")
  `FLFB_ASSERT(a_reset_empty, clk, rst |=> (!s1_valid && !out_valid),
    "pipeline not empty after reset")

endmodule

// ===== test/front_light_fade_blink_checker.sv =====
// Watches the command, result and config channels of the front light controller and checks every result.
`timescale 1ns / 100ps

module front_light_fade_blink_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [2:0]                     action,
  input  logic [7:0]                     value,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [7:0]                     led_level,
  input  logic [7:0]                     led_scale,
  input  logic                           light_on,
  input  logic                           blinking,
  input  logic                           fade_active,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [flfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  output int                             mismatch_count,
  output int                             results_due
);
  import flfb_pkg::*;

  logic [15:0]  fade_ivl, blink_ivl;
  logic [7:0]   bright, level;
  logic         blink_mode, lit, fading_up, fade_run, blink_run;
  logic [8:0]   ramp_up;
  int           ramp_down;
  logic [15:0]  fade_left, blink_left;
  flfb_result_t led_results_q[$];
  flfb_result_t want;

  function automatic void reset_light();
    fade_ivl   = FADE_IVL_RESET;
    blink_ivl  = BLINK_IVL_RESET;
    bright     = BRIGHT_RESET;
    blink_mode = 1'b0;
    lit        = 1'b0;
    fading_up  = 1'b0;
    ramp_up    = '0;
    ramp_down  = 255;
    fade_run   = 1'b0;
    fade_left  = '0;
    blink_run  = 1'b0;
    blink_left = '0;
    level      = '0;
  endfunction

  // a zero interval counts as one tick
  function automatic void load_fade_timer();
    fade_run  = 1'b1;
    fade_left = (fade_ivl == 16'd0) ? 16'd1 : fade_ivl;
  endfunction

  function automatic void load_blink_timer();
    blink_run  = 1'b1;
    blink_left = (blink_ivl == 16'd0) ? 16'd1 : blink_ivl;
  endfunction

  function automatic void toggle_blink();
    if (!blink_mode) return;
    if (lit) begin
      level = '0;
      lit   = 1'b0;
    end else begin
      level = LEVEL_FULL;
      lit   = 1'b1;
    end
  endfunction

  function automatic flfb_result_t predict_led_result(input logic [2:0] act,
                                                      input logic [7:0] val);
    flfb_result_t r;
    case (act)
      ACT_TICK: begin
        // fade timer is served before the blink timer
        if (fade_run) begin
          fade_left = fade_left - 16'd1;
          if (fade_left == 16'd0) begin
            fade_run = 1'b0;
            if (fading_up) begin
              ramp_down = 255;
              ramp_up   = ramp_up + ((ramp_up < RAMP_KNEE) ? 9'd1 : 9'd2);
              if (ramp_up < {1'b0, bright}) begin
                level = ramp_up[7:0];
                load_fade_timer();
              end else begin
                ramp_up   = '0;
                ramp_down = int'(bright);
                level     = bright;
              end
            end else begin
              ramp_up   = '0;
              ramp_down = ramp_down - 2;
              if (ramp_down > 0) begin
                level = 8'(ramp_down);
                load_fade_timer();
              end else begin
                ramp_down = int'(bright);
                level     = '0;
              end
            end
          end
        end
        if (blink_run) begin
          blink_left = blink_left - 16'd1;
          if (blink_left == 16'd0) begin
            blink_run = 1'b0;
            toggle_blink();
            if (blink_mode) load_blink_timer();
          end
        end
      end
      ACT_LIGHT_ON: begin
        fading_up = 1'b1;
        load_fade_timer();
        blink_mode = 1'b0;
        lit        = 1'b1;
      end
      ACT_LIGHT_OFF: begin
        fading_up = 1'b0;
        load_fade_timer();
        lit = 1'b0;
      end
      ACT_BLINK_START: begin
        blink_mode = 1'b1;
        toggle_blink();
        load_blink_timer();
      end
      ACT_BLINK_STOP: blink_mode = 1'b0;
      ACT_SET_BRIGHT: bright = val;
      default: ;
    endcase
    r.level = level;
    r.scale = bright;
    r.on    = lit;
    r.blink = blink_mode;
    r.fade  = fade_run;
    return r;
  endfunction

  function automatic void check_field(input string field, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, field, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reset_light();
      led_results_q.delete();
      results_due <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FADE_IVL) fade_ivl = cfg_data;
        else if (cfg_index == CFG_BLINK_IVL) blink_ivl = cfg_data;
      end
      if (in_valid && !in_stall) led_results_q.push_back(predict_led_result(action, value));
      if (out_valid && !out_stall) begin
        if (led_results_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, got level %0d scale %0d",
                   $time, led_level, led_scale);
        end else begin
          want = led_results_q.pop_front();
          check_field("led_level", int'(want.level), int'(led_level));
          check_field("led_scale", int'(want.scale), int'(led_scale));
          check_field("light_on", int'(want.on), int'(light_on));
          check_field("blinking", int'(want.blink), int'(blinking));
          check_field("fade_active", int'(want.fade), int'(fade_active));
        end
      end
      results_due <= led_results_q.size();
    end
  end

endmodule

// ===== test/tb_front_light_fade_blink_controller.sv =====
// Testbench top: drives commands, ticks and interval settings into the front light controller.
`timescale 1ns / 100ps

module tb_front_light_fade_blink_controller;
  import flfb_pkg::*;

  localparam logic [2:0]           ACT_SPARE_6   = 3'd6;
  localparam logic [2:0]           ACT_SPARE_7   = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           action = '0;
  logic [7:0]           value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           led_level, led_scale;
  logic                 light_on, blinking, fade_active;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  int                   mismatch_count;
  int                   results_due;
  bit                   calm = 1'b0;

  logic [15:0] fade_steps  [8] = '{16'd1, 16'd0, 16'd2, 16'd1, 16'd3, 16'd65535, 16'd1, 16'd5};
  logic [15:0] blink_steps [8] = '{16'd2, 16'd1, 16'd5, 16'd0, 16'd1, 16'd65535, 16'd3, 16'd7};

  front_light_fade_blink_controller uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .led_level(led_level), .led_scale(led_scale),
    .light_on(light_on), .blinking(blinking), .fade_active(fade_active),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  front_light_fade_blink_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .led_level(led_level), .led_scale(led_scale),
    .light_on(light_on), .blinking(blinking), .fade_active(fade_active),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .results_due(results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(0, 99) < 29);
  end

  task automatic send_item(input logic [2:0] act, input logic [7:0] val);
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic program_intervals(input logic [15:0] fade_ticks, input logic [15:0] blink_ticks,
                                   input bit poke_spare);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FADE_IVL;
    cfg_data  <= fade_ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_BLINK_IVL;
    cfg_data  <= blink_ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (poke_spare) begin
      cfg_index <= CFG_IDX_SPARE;
      cfg_data  <= 16'hFFFF;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly ticks and tick bursts so fades and blinks run to completion
  task automatic run_random(input int n);
    int sent;
    int pick;
    int burst;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        burst = $urandom_range(5, 40);
        for (int i = 0; i < burst; i++) send_item(ACT_TICK, 8'($urandom));
        sent += burst;
      end else begin
        if (pick < 55) send_item(ACT_TICK, 8'($urandom));
        else if (pick < 65) send_item(ACT_LIGHT_ON, 8'($urandom));
        else if (pick < 75) send_item(ACT_LIGHT_OFF, 8'($urandom));
        else if (pick < 80) send_item(ACT_BLINK_START, 8'($urandom));
        else if (pick < 84) send_item(ACT_BLINK_STOP, 8'($urandom));
        else if (pick < 96)
          send_item(ACT_SET_BRIGHT, ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                                                                : 8'($urandom_range(0, 60)));
        else send_item(($urandom_range(0, 1) != 0) ? ACT_SPARE_6 : ACT_SPARE_7, 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    run_random(120);

    drain_results();
    program_intervals(16'd1, 16'd2, 1'b1);
    send_item(ACT_SET_BRIGHT, 8'h00);
    send_item(ACT_LIGHT_ON, 8'hFF);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_LIGHT_OFF, 8'h00);
    send_item(ACT_TICK, 8'hFF);
    send_item(ACT_SET_BRIGHT, 8'hFF);
    send_item(ACT_SET_BRIGHT, 8'h03);
    send_item(ACT_LIGHT_ON, 8'h00);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_LIGHT_OFF, 8'h00);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_BLINK_START, 8'h00);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_TICK, 8'h00);
    // stop with a blink expiry still pending
    send_item(ACT_BLINK_STOP, 8'h00);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_SPARE_6, 8'hAA);
    send_item(ACT_SPARE_7, 8'h55);
    send_item(ACT_BLINK_START, 8'h00);
    send_item(ACT_LIGHT_ON, 8'h00);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_SET_BRIGHT, 8'h80);

    for (int p = 0; p < 8; p++) begin
      drain_results();
      program_intervals(fade_steps[p], blink_steps[p], 1'b0);
      calm = (p == 3);
      run_random((p == 5) ? 50 : 140);
    end
    calm = 1'b0;

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
